@@ rtl/dhrc_pkg.sv @@
// Package for the dual hysteresis relay controller.
// Holds constants, register map codes and the struct types shared by the step logic, the top level and the testbench.
// No dependencies.
package dhrc_pkg;

    // Minimum time between two ticks and minimum time between relay switches, in ms
    localparam logic [31:0] TICK_INTERVAL_MS    = 32'd1000;
    localparam logic [31:0] RELAY_MIN_SWITCH_MS = 32'd10000;

    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 32;

    typedef enum logic [2:0] {
        REG_TEMP_HYST       = 3'd0,
        REG_HUM_HYST        = 3'd1,
        REG_TEMP_ALARM_HIGH = 3'd2,
        REG_TEMP_ALARM_LOW  = 3'd3,
        REG_HUM_ALARM_HIGH  = 3'd4,
        REG_HUM_ALARM_LOW   = 3'd5,
        REG_ALARM_CONFIRM   = 3'd6,
        REG_BUZZER_ENABLE   = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [12:0] temp_hysteresis;
        logic [12:0] humidity_hysteresis;
        logic [13:0] temp_alarm_high;
        logic [13:0] temp_alarm_low;
        logic [13:0] humidity_alarm_high;
        logic [13:0] humidity_alarm_low;
        logic [31:0] alarm_confirm_time;
        logic        buzzer_enable;
    } cfg_t;

    typedef struct packed {
        logic [31:0]        now_ms;
        logic signed [15:0] temp_reading;
        logic signed [15:0] temp_target;
        logic [13:0]        humidity_reading;
        logic [13:0]        humidity_target;
        logic               temp_sensor_good;
        logic               humidity_sensor_good;
        logic               manual_override;
        logic               safe_mode;
        logic               batch_running;
    } sample_t;

    typedef struct packed {
        logic [31:0] last_tick_time;
        logic [31:0] heater_switch_time;
        logic [31:0] humidifier_switch_time;
        logic        heater_relay;
        logic        humidifier_relay;
        logic        buzzer_state;
        logic [31:0] temp_out_time;
        logic [31:0] humidity_out_time;
        logic        temp_alarm_flag;
        logic        humidity_alarm_flag;
    } state_t;

    typedef struct packed {
        logic heater_on;
        logic humidifier_on;
        logic buzzer_on;
        logic temp_alarm;
        logic humidity_alarm;
        logic tick_taken;
    } result_t;

endpackage

@@ rtl/dhrc_sample_if.sv @@
// Valid/ready channel carrying one controller time sample.
// Standalone; used by the controller top level.
interface dhrc_sample_if;
    logic               valid;
    logic               ready;
    logic [31:0]        now_ms;
    logic signed [15:0] temp_reading;
    logic signed [15:0] temp_target;
    logic [13:0]        humidity_reading;
    logic [13:0]        humidity_target;
    logic               temp_sensor_good;
    logic               humidity_sensor_good;
    logic               manual_override;
    logic               safe_mode;
    logic               batch_running;

    modport source (
        output valid, now_ms, temp_reading, temp_target, humidity_reading,
               humidity_target, temp_sensor_good, humidity_sensor_good,
               manual_override, safe_mode, batch_running,
        input  ready
    );

    modport sink (
        input  valid, now_ms, temp_reading, temp_target, humidity_reading,
               humidity_target, temp_sensor_good, humidity_sensor_good,
               manual_override, safe_mode, batch_running,
        output ready
    );
endinterface

@@ rtl/dhrc_status_if.sv @@
// Valid/ready channel carrying one controller status word.
// Standalone; used by the controller top level.
interface dhrc_status_if;
    logic valid;
    logic ready;
    logic heater_on;
    logic humidifier_on;
    logic buzzer_on;
    logic temp_alarm;
    logic humidity_alarm;
    logic tick_taken;

    modport source (
        output valid, heater_on, humidifier_on, buzzer_on, temp_alarm,
               humidity_alarm, tick_taken,
        input  ready
    );

    modport sink (
        input  valid, heater_on, humidifier_on, buzzer_on, temp_alarm,
               humidity_alarm, tick_taken,
        output ready
    );
endinterface

@@ rtl/dhrc_step.sv @@
// Next-state logic of the controller for one time sample: tick check,
// relay hysteresis with minimum switch time, alarm accumulation and buzzer.
// Depends on dhrc_pkg.
module dhrc_step (
    input  dhrc_pkg::sample_t sample,
    input  dhrc_pkg::cfg_t    cfg,
    input  dhrc_pkg::state_t  cur,
    output dhrc_pkg::state_t  nxt,
    output logic              took
);

    logic [31:0]        delta;
    logic signed [17:0] t_cur, t_tgt, h_cur, h_tgt;
    logic signed [17:0] t_hyst, h_hyst;
    logic signed [17:0] t_err, h_err;
    logic               heat_want, hum_want;
    logic               heat_may, hum_may;
    logic               t_oob, h_oob;
    logic [32:0]        t_sum, h_sum;
    logic [31:0]        t_acc, h_acc;
    logic               t_conf, h_conf;
    logic               t_flag, h_flag;
    logic               buzz;
    logic [31:0]        heat_age, hum_age;

    always_comb
    begin
        delta = sample.now_ms - cur.last_tick_time;
        took  = (delta >= dhrc_pkg::TICK_INTERVAL_MS);

        t_cur  = {{2{sample.temp_reading[15]}}, sample.temp_reading};
        t_tgt  = {{2{sample.temp_target[15]}}, sample.temp_target};
        h_cur  = {4'd0, sample.humidity_reading};
        h_tgt  = {4'd0, sample.humidity_target};
        t_hyst = {5'd0, cfg.temp_hysteresis};
        h_hyst = {5'd0, cfg.humidity_hysteresis};
        t_err  = t_cur - t_tgt;
        h_err  = h_cur - h_tgt;

        // A relay wants to flip: off on a failed sensor, else past the band edge
        if (!sample.temp_sensor_good)
            heat_want = cur.heater_relay;
        else if (cur.heater_relay)
            heat_want = (t_cur > t_tgt + t_hyst);
        else
            heat_want = (t_cur < t_tgt - t_hyst);

        if (!sample.humidity_sensor_good)
            hum_want = cur.humidifier_relay;
        else if (cur.humidifier_relay)
            hum_want = (h_cur > h_tgt + h_hyst);
        else
            hum_want = (h_cur < h_tgt - h_hyst);

        // switch time of zero reads as never switched
        heat_age = sample.now_ms - cur.heater_switch_time;
        hum_age  = sample.now_ms - cur.humidifier_switch_time;
        heat_may = (cur.heater_switch_time == 32'd0)
                   || (heat_age >= dhrc_pkg::RELAY_MIN_SWITCH_MS);
        hum_may  = (cur.humidifier_switch_time == 32'd0)
                   || (hum_age >= dhrc_pkg::RELAY_MIN_SWITCH_MS);

        t_oob = sample.temp_sensor_good
                && ((t_err > $signed({4'd0, cfg.temp_alarm_high}))
                    || (t_err < -$signed({4'd0, cfg.temp_alarm_low})));
        h_oob = sample.humidity_sensor_good
                && ((h_err > $signed({4'd0, cfg.humidity_alarm_high}))
                    || (h_err < -$signed({4'd0, cfg.humidity_alarm_low})));

        // saturating out-of-band time
        t_sum = {1'b0, cur.temp_out_time} + {1'b0, delta};
        h_sum = {1'b0, cur.humidity_out_time} + {1'b0, delta};
        t_acc = t_oob ? (t_sum[32] ? '1 : t_sum[31:0]) : 32'd0;
        h_acc = h_oob ? (h_sum[32] ? '1 : h_sum[31:0]) : 32'd0;
        t_conf = t_oob && (t_acc >= cfg.alarm_confirm_time);
        h_conf = h_oob && (h_acc >= cfg.alarm_confirm_time);
        t_flag = t_oob && (t_conf || cur.temp_alarm_flag);
        h_flag = h_oob && (h_conf || cur.humidity_alarm_flag);

        if (!t_flag && !h_flag)
            buzz = 1'b0;
        else if ((t_conf || h_conf) && cfg.buzzer_enable)
            buzz = 1'b1;
        else
            buzz = cur.buzzer_state;

        nxt = cur;
        if (took)
        begin
            nxt.last_tick_time = sample.now_ms;
            priority if (sample.manual_override)
            begin
                // frozen
            end
            else if (sample.safe_mode || !sample.batch_running)
            begin
                nxt.heater_relay        = 1'b0;
                nxt.humidifier_relay    = 1'b0;
                nxt.buzzer_state        = 1'b0;
                nxt.temp_alarm_flag     = 1'b0;
                nxt.humidity_alarm_flag = 1'b0;
            end
            else
            begin
                if (heat_want && heat_may)
                begin
                    nxt.heater_relay       = !cur.heater_relay;
                    nxt.heater_switch_time = sample.now_ms;
                end
                if (hum_want && hum_may)
                begin
                    nxt.humidifier_relay       = !cur.humidifier_relay;
                    nxt.humidifier_switch_time = sample.now_ms;
                end
                nxt.temp_out_time       = t_acc;
                nxt.humidity_out_time   = h_acc;
                nxt.temp_alarm_flag     = t_flag;
                nxt.humidity_alarm_flag = h_flag;
                nxt.buzzer_state        = buzz;
            end
        end
    end

endmodule

@@ rtl/dual_hysteresis_relay_controller_core.sv @@
// Top level of the dual hysteresis relay controller: channels, APB registers,
// controller state and result register. Depends on dhrc_pkg, dhrc_sample_if,
// dhrc_status_if and dhrc_step.
//
// Usage: time samples arrive on the sample channel (valid/ready), one status
// word per sample leaves on the status channel. A sample is taken into an
// input register, then the controller state and the status word are updated
// together when the status register is free or being taken, and the block
// takes one sample per cycle when the receiver keeps up; the state update
// loop (tick check, relay and alarm logic) sets that rate. When the receiver
// stalls, the status register holds its word and the input register holds
// one more sample; the sample channel then drops ready until the status word
// is taken. Registers are written over APB at byte address 4*i; the user
// must write them only while the block is idle, and the block does not
// enforce it. Reads return the current values. pready is always high.
// Reset (rst_n low) clears both channel stages, relays, buzzer, alarms, times
// and loads the register defaults.
module dual_hysteresis_relay_controller_core (
    input  logic                          clk,
    input  logic                          rst_n,
    dhrc_sample_if.sink                   sample,
    dhrc_status_if.source                 status,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dhrc_pkg::ADDR_W-1:0]   paddr,
    input  logic [dhrc_pkg::DATA_W-1:0]   pwdata,
    output logic [dhrc_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    dhrc_pkg::cfg_t      cfg_reg;
    dhrc_pkg::sample_t   sample_reg;
    logic                sample_valid_reg;
    dhrc_pkg::state_t    state_reg;
    dhrc_pkg::state_t    state_next;
    dhrc_pkg::result_t   result_reg;
    logic                result_valid_reg;
    logic                took;
    logic                advance;
    logic                cfg_write;
    dhrc_pkg::reg_idx_t  reg_idx;

    // ---------------- APB registers ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_idx   = dhrc_pkg::reg_idx_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.temp_hysteresis     <= 13'd50;
            cfg_reg.humidity_hysteresis <= 13'd200;
            cfg_reg.temp_alarm_high     <= 14'd100;
            cfg_reg.temp_alarm_low      <= 14'd100;
            cfg_reg.humidity_alarm_high <= 14'd1000;
            cfg_reg.humidity_alarm_low  <= 14'd1000;
            cfg_reg.alarm_confirm_time  <= 32'd60000;
            cfg_reg.buzzer_enable       <= 1'b1;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                dhrc_pkg::REG_TEMP_HYST:       cfg_reg.temp_hysteresis     <= pwdata[12:0];
                dhrc_pkg::REG_HUM_HYST:        cfg_reg.humidity_hysteresis <= pwdata[12:0];
                dhrc_pkg::REG_TEMP_ALARM_HIGH: cfg_reg.temp_alarm_high     <= pwdata[13:0];
                dhrc_pkg::REG_TEMP_ALARM_LOW:  cfg_reg.temp_alarm_low      <= pwdata[13:0];
                dhrc_pkg::REG_HUM_ALARM_HIGH:  cfg_reg.humidity_alarm_high <= pwdata[13:0];
                dhrc_pkg::REG_HUM_ALARM_LOW:   cfg_reg.humidity_alarm_low  <= pwdata[13:0];
                dhrc_pkg::REG_ALARM_CONFIRM:   cfg_reg.alarm_confirm_time  <= pwdata;
                dhrc_pkg::REG_BUZZER_ENABLE:   cfg_reg.buzzer_enable       <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            dhrc_pkg::REG_TEMP_HYST:       prdata = {19'd0, cfg_reg.temp_hysteresis};
            dhrc_pkg::REG_HUM_HYST:        prdata = {19'd0, cfg_reg.humidity_hysteresis};
            dhrc_pkg::REG_TEMP_ALARM_HIGH: prdata = {18'd0, cfg_reg.temp_alarm_high};
            dhrc_pkg::REG_TEMP_ALARM_LOW:  prdata = {18'd0, cfg_reg.temp_alarm_low};
            dhrc_pkg::REG_HUM_ALARM_HIGH:  prdata = {18'd0, cfg_reg.humidity_alarm_high};
            dhrc_pkg::REG_HUM_ALARM_LOW:   prdata = {18'd0, cfg_reg.humidity_alarm_low};
            dhrc_pkg::REG_ALARM_CONFIRM:   prdata = cfg_reg.alarm_confirm_time;
            dhrc_pkg::REG_BUZZER_ENABLE:   prdata = {31'd0, cfg_reg.buzzer_enable};
            default:                       prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    // input stage moves on whenever the status register is free or being taken
    assign advance      = sample_valid_reg && (!result_valid_reg || status.ready);
    assign sample.ready = !sample_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_valid_reg <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (sample.valid && sample.ready)
                sample_valid_reg <= 1'b1;
            else if (advance)
                sample_valid_reg <= 1'b0;

            if (advance)
                result_valid_reg <= 1'b1;
            else if (status.ready)
                result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            sample_reg.now_ms               <= sample.now_ms;
            sample_reg.temp_reading         <= sample.temp_reading;
            sample_reg.temp_target          <= sample.temp_target;
            sample_reg.humidity_reading     <= sample.humidity_reading;
            sample_reg.humidity_target      <= sample.humidity_target;
            sample_reg.temp_sensor_good     <= sample.temp_sensor_good;
            sample_reg.humidity_sensor_good <= sample.humidity_sensor_good;
            sample_reg.manual_override      <= sample.manual_override;
            sample_reg.safe_mode            <= sample.safe_mode;
            sample_reg.batch_running        <= sample.batch_running;
        end
        if (advance)
        begin
            result_reg.heater_on      <= state_next.heater_relay;
            result_reg.humidifier_on  <= state_next.humidifier_relay;
            result_reg.buzzer_on      <= state_next.buzzer_state;
            result_reg.temp_alarm     <= state_next.temp_alarm_flag;
            result_reg.humidity_alarm <= state_next.humidity_alarm_flag;
            result_reg.tick_taken     <= took;
        end
    end

    // ---------------- controller state ----------------
    dhrc_step u_step (
        .sample (sample_reg),
        .cfg    (cfg_reg),
        .cur    (state_reg),
        .nxt    (state_next),
        .took   (took)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (advance)
            state_reg <= state_next;
    end

    assign status.valid          = result_valid_reg;
    assign status.heater_on      = result_reg.heater_on;
    assign status.humidifier_on  = result_reg.humidifier_on;
    assign status.buzzer_on      = result_reg.buzzer_on;
    assign status.temp_alarm     = result_reg.temp_alarm;
    assign status.humidity_alarm = result_reg.humidity_alarm;
    assign status.tick_taken     = result_reg.tick_taken;

    // ---------------- assertions ----------------
    a_buzzer_needs_alarm: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.buzzer_state |-> (state_reg.temp_alarm_flag || state_reg.humidity_alarm_flag))
        else $error("buzzer on with no active alarm");

    a_no_tick_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !took) |=> $stable(state_reg))
        else $error("state changed on a sample without a tick");

    a_state_only_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("state changed with no sample in flight");

    a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !sample.ready |-> (sample_valid_reg && result_valid_reg && !status.ready))
        else $error("sample channel blocked with a free stage");

endmodule

@@ dv/testbench.sv @@
// Testbench for the dual hysteresis relay controller core: drives time samples
// and APB register writes, predicts each status word and checks it in order.
// Depends on dhrc_pkg, dhrc_sample_if, dhrc_status_if and the core top level.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 2000;
    localparam int LONG_HOLD   = 200;

    // {temp_sensor_good, humidity_sensor_good, manual_override, safe_mode, batch_running}
    localparam logic [4:0] MODE_RUN         = 5'b11001;
    localparam logic [4:0] MODE_MANUAL      = 5'b11101;
    localparam logic [4:0] MODE_SAFE        = 5'b11011;
    localparam logic [4:0] MODE_NO_BATCH    = 5'b11000;
    localparam logic [4:0] MODE_SENSORS_BAD = 5'b00001;
    localparam logic [4:0] MODE_HUM_BAD     = 5'b10001;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [dhrc_pkg::ADDR_W-1:0] paddr;
    logic [dhrc_pkg::DATA_W-1:0] pwdata;
    logic [dhrc_pkg::DATA_W-1:0] prdata;
    logic                        pready;

    dhrc_sample_if sample_ch();
    dhrc_status_if status_ch();

    dual_hysteresis_relay_controller_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .sample  (sample_ch),
        .status  (status_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #2 clk = ~clk;

    // predictor copy of the registers and the controller state
    dhrc_pkg::cfg_t regs_model;
    logic [31:0] ctl_last_tick    = '0;
    logic [31:0] ctl_heater_stamp = '0;
    logic [31:0] ctl_humid_stamp  = '0;
    logic [31:0] ctl_temp_out     = '0;
    logic [31:0] ctl_humid_out    = '0;
    bit          ctl_heater;
    bit          ctl_humid;
    bit          ctl_buzzer;
    bit          ctl_temp_alarm;
    bit          ctl_humid_alarm;

    dhrc_pkg::result_t expected_status[$];
    int          mismatches = 0;
    int          idle_cycles = 0;
    bit          sender_steady;
    bit          receiver_steady;
    bit          hold_request;

    // stimulus plant: time cursor and drifting readings
    logic [31:0]        clock_ms    = '0;
    logic signed [15:0] temp_goal   = 16'sd2000;
    logic signed [15:0] temp_level  = 16'sd2000;
    logic [13:0]        humid_goal  = 14'd5000;
    logic [13:0]        humid_level = 14'd5000;

    function automatic bit switch_granted(logic [31:0] now, inout logic [31:0] stamp);
        if (stamp == 32'd0 || now - stamp >= dhrc_pkg::RELAY_MIN_SWITCH_MS) begin
            stamp = now;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void steer_relay(bit ok, int cur, int goal, int band, logic [31:0] now,
                                        inout bit relay, inout logic [31:0] stamp);
        if (!ok) begin
            if (relay && switch_granted(now, stamp))
                relay = 1'b0;
        end else if (cur < goal - band && !relay) begin
            if (switch_granted(now, stamp))
                relay = 1'b1;
        end else if (cur > goal + band && relay) begin
            if (switch_granted(now, stamp))
                relay = 1'b0;
        end
    endfunction

    function automatic void track_band(bit ok, int err, int above, int below, logic [31:0] gap,
                                       inout logic [31:0] acc, inout bit alarm);
        logic [32:0] sum;
        if ((err > above || err < -below) && ok) begin
            sum = {1'b0, acc} + {1'b0, gap};
            acc = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            if (acc >= regs_model.alarm_confirm_time) begin
                alarm = 1'b1;
                if (regs_model.buzzer_enable)
                    ctl_buzzer = 1'b1;
            end
        end else begin
            acc   = '0;
            alarm = 1'b0;
        end
    endfunction

    function automatic dhrc_pkg::result_t step_controller(dhrc_pkg::sample_t s);
        logic [31:0]       gap;
        bit                took;
        int                t_cur;
        int                t_goal;
        int                h_cur;
        int                h_goal;
        dhrc_pkg::result_t r;
        t_cur  = $signed(s.temp_reading);
        t_goal = $signed(s.temp_target);
        h_cur  = s.humidity_reading;
        h_goal = s.humidity_target;
        gap    = s.now_ms - ctl_last_tick;
        took   = gap >= dhrc_pkg::TICK_INTERVAL_MS;
        if (took) begin
            ctl_last_tick = s.now_ms;
            if (!s.manual_override) begin
                if (s.safe_mode || !s.batch_running) begin
                    ctl_heater      = 1'b0;
                    ctl_humid       = 1'b0;
                    ctl_buzzer      = 1'b0;
                    ctl_temp_alarm  = 1'b0;
                    ctl_humid_alarm = 1'b0;
                end else begin
                    steer_relay(s.temp_sensor_good, t_cur, t_goal,
                                regs_model.temp_hysteresis, s.now_ms,
                                ctl_heater, ctl_heater_stamp);
                    steer_relay(s.humidity_sensor_good, h_cur, h_goal,
                                regs_model.humidity_hysteresis, s.now_ms,
                                ctl_humid, ctl_humid_stamp);
                    track_band(s.temp_sensor_good, t_cur - t_goal,
                               regs_model.temp_alarm_high, regs_model.temp_alarm_low,
                               gap, ctl_temp_out, ctl_temp_alarm);
                    track_band(s.humidity_sensor_good, h_cur - h_goal,
                               regs_model.humidity_alarm_high, regs_model.humidity_alarm_low,
                               gap, ctl_humid_out, ctl_humid_alarm);
                    if (!ctl_temp_alarm && !ctl_humid_alarm)
                        ctl_buzzer = 1'b0;
                end
            end
        end
        r.heater_on      = ctl_heater;
        r.humidifier_on  = ctl_humid;
        r.buzzer_on      = ctl_buzzer;
        r.temp_alarm     = ctl_temp_alarm;
        r.humidity_alarm = ctl_humid_alarm;
        r.tick_taken     = took;
        return r;
    endfunction

    function automatic void flag_mismatch(string what, dhrc_pkg::result_t want,
                                          dhrc_pkg::result_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s: heat/hum/buzz/talm/halm/tick expected %6b got %6b",
                     $time, what, want, got);
    endfunction

    // next sample of a closed loop: readings drift with the predicted relays
    function automatic dhrc_pkg::sample_t drifting_sample();
        dhrc_pkg::sample_t s;
        int                pick;
        int                step;
        pick = $urandom_range(0, 99);
        if (pick < 15)
            clock_ms = clock_ms + $urandom_range(0, 999);
        else if (pick < 20)
            clock_ms = clock_ms + dhrc_pkg::TICK_INTERVAL_MS;
        else if (pick < 75)
            clock_ms = clock_ms + $urandom_range(1000, 3000);
        else if (pick < 94)
            clock_ms = clock_ms + $urandom_range(3000, 20000);
        else
            clock_ms = $urandom();

        if ($urandom_range(0, 24) == 0) begin
            temp_goal = ($urandom_range(0, 3) == 0) ? 16'($urandom())
                                                    : 16'($urandom_range(0, 6000) - 2000);
            temp_level = temp_goal;
        end
        if ($urandom_range(0, 24) == 0) begin
            humid_goal = ($urandom_range(0, 3) == 0) ? 14'($urandom())
                                                     : 14'($urandom_range(0, 10000));
            humid_level = humid_goal;
        end
        step = ctl_heater ? $urandom_range(0, 70) - 20 : 20 - $urandom_range(0, 70);
        temp_level = temp_level + 16'(step);
        step = ctl_humid ? $urandom_range(0, 250) - 80 : 80 - $urandom_range(0, 250);
        humid_level = humid_level + 14'(step);

        s.now_ms               = clock_ms;
        s.temp_reading         = ($urandom_range(0, 19) == 0) ? 16'($urandom()) : temp_level;
        s.temp_target          = temp_goal;
        s.humidity_reading     = ($urandom_range(0, 19) == 0) ? 14'($urandom()) : humid_level;
        s.humidity_target      = humid_goal;
        s.temp_sensor_good     = $urandom_range(0, 11) != 0;
        s.humidity_sensor_good = $urandom_range(0, 11) != 0;
        s.manual_override      = $urandom_range(0, 19) == 0;
        s.safe_mode            = $urandom_range(0, 24) == 0;
        s.batch_running        = $urandom_range(0, 24) != 0;
        return s;
    endfunction

    task automatic send_sample(dhrc_pkg::sample_t s);
        int gap;
        gap = sender_steady ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid                <= 1'b1;
        sample_ch.now_ms               <= s.now_ms;
        sample_ch.temp_reading         <= s.temp_reading;
        sample_ch.temp_target          <= s.temp_target;
        sample_ch.humidity_reading     <= s.humidity_reading;
        sample_ch.humidity_target      <= s.humidity_target;
        sample_ch.temp_sensor_good     <= s.temp_sensor_good;
        sample_ch.humidity_sensor_good <= s.humidity_sensor_good;
        sample_ch.manual_override      <= s.manual_override;
        sample_ch.safe_mode            <= s.safe_mode;
        sample_ch.batch_running        <= s.batch_running;
        do @(posedge clk); while (!sample_ch.ready);
        expected_status.push_back(step_controller(s));
    endtask

    task automatic send_at(logic [31:0] now, int tr, int tt, int hr, int ht, logic [4:0] mode);
        dhrc_pkg::sample_t s;
        s.now_ms           = now;
        s.temp_reading     = 16'(tr);
        s.temp_target      = 16'(tt);
        s.humidity_reading = 14'(hr);
        s.humidity_target  = 14'(ht);
        {s.temp_sensor_good, s.humidity_sensor_good, s.manual_override,
         s.safe_mode, s.batch_running} = mode;
        clock_ms = now;
        send_sample(s);
    endtask

    task automatic run_random(int count);
        repeat (count) send_sample(drifting_sample());
    endtask

    task automatic drain_status();
        sample_ch.valid <= 1'b0;
        while (expected_status.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // back-to-back transfers keep psel high; the caller closes the burst
    task automatic write_reg(dhrc_pkg::reg_idx_t idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (idx)
            dhrc_pkg::REG_TEMP_HYST:       regs_model.temp_hysteresis     = value[12:0];
            dhrc_pkg::REG_HUM_HYST:        regs_model.humidity_hysteresis = value[12:0];
            dhrc_pkg::REG_TEMP_ALARM_HIGH: regs_model.temp_alarm_high     = value[13:0];
            dhrc_pkg::REG_TEMP_ALARM_LOW:  regs_model.temp_alarm_low      = value[13:0];
            dhrc_pkg::REG_HUM_ALARM_HIGH:  regs_model.humidity_alarm_high = value[13:0];
            dhrc_pkg::REG_HUM_ALARM_LOW:   regs_model.humidity_alarm_low  = value[13:0];
            dhrc_pkg::REG_ALARM_CONFIRM:   regs_model.alarm_confirm_time  = value;
            dhrc_pkg::REG_BUZZER_ENABLE:   regs_model.buzzer_enable       = value[0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(logic [31:0] t_hyst, logic [31:0] h_hyst,
                                  logic [31:0] t_high, logic [31:0] t_low,
                                  logic [31:0] h_high, logic [31:0] h_low,
                                  logic [31:0] confirm, logic [31:0] buzz);
        drain_status();
        write_reg(dhrc_pkg::REG_TEMP_HYST, t_hyst);
        write_reg(dhrc_pkg::REG_HUM_HYST, h_hyst);
        write_reg(dhrc_pkg::REG_TEMP_ALARM_HIGH, t_high);
        write_reg(dhrc_pkg::REG_TEMP_ALARM_LOW, t_low);
        write_reg(dhrc_pkg::REG_HUM_ALARM_HIGH, h_high);
        write_reg(dhrc_pkg::REG_HUM_ALARM_LOW, h_low);
        write_reg(dhrc_pkg::REG_ALARM_CONFIRM, confirm);
        write_reg(dhrc_pkg::REG_BUZZER_ENABLE, buzz);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // runs on the reset register values
    task automatic test_directed_cases();
        send_at(32'd500, 1000, 2000, 5000, 5000, MODE_RUN);           // interval not elapsed
        send_at(32'd1000, -32768, 32767, 0, 16383, MODE_RUN);         // tick right at the interval
        send_at(32'hFFFF_FFFF, -32768, 32767, 0, 16383, MODE_RUN);    // huge delta confirms alarms
        send_at(32'h7FFF_FFFF, 32767, -32768, 16383, 0, MODE_RUN);    // out-of-band sum saturates
        send_at(clock_ms + 2000, -1000, 0, 2000, 5000, MODE_RUN);     // min switch time blocks
        send_at(clock_ms + 999, -1000, 0, 2000, 5000, MODE_RUN);
        send_at(clock_ms + 1001, 0, 0, 5000, 5000, MODE_MANUAL);
        send_at(clock_ms + 1000, -1000, 0, 2000, 5000, MODE_SAFE);
        send_at(clock_ms + 1000, -1000, 0, 2000, 5000, MODE_NO_BATCH);
        send_at(clock_ms + 10000, -1000, 0, 2000, 5000, MODE_RUN);
        send_at(clock_ms + 10000, 0, 0, 5000, 5000, MODE_SENSORS_BAD);
        // a switch granted at time zero later reads as never switched
        send_at(32'hFFFF_0000, -1000, 0, 2000, 5000, MODE_RUN);
        send_at(32'd0, 1000, 0, 9000, 5000, MODE_RUN);
        send_at(32'd1000, -1000, 0, 2000, 5000, MODE_RUN);
        // hysteresis band edges
        send_at(32'd11000, 50, 0, 5200, 5000, MODE_RUN);
        send_at(32'd12000, 51, 0, 5201, 5000, MODE_RUN);
        send_at(32'd13000, -50, 0, 4800, 5000, MODE_RUN);
        send_at(32'd25000, -51, 0, 4799, 5000, MODE_RUN);
        // alarm band edges
        send_at(32'd26000, 100, 0, 6000, 5000, MODE_RUN);
        send_at(32'd27000, 101, 0, 6001, 5000, MODE_RUN);
        send_at(32'd28000, 101, 0, 6001, 5000, MODE_HUM_BAD);
    endtask

    task automatic test_settings_sweep();
        apply_settings(0, 0, 0, 0, 0, 0, 0, 0);
        run_random(200);
        sender_steady   = 1'b1;
        receiver_steady = 1'b1;
        apply_settings(5000, 5000, 10000, 10000, 10000, 10000, 32'hFFFF_FFFF, 1);
        run_random(150);
        sender_steady   = 1'b0;
        receiver_steady = 1'b0;
        apply_settings(50, 200, 100, 100, 1000, 1000, 5000, 1);
        run_random(250);
        apply_settings(20, 100, 50, 50, 300, 300, 3000, 0);
        run_random(100);
        repeat (2) begin
            apply_settings($urandom_range(0, 5000), $urandom_range(0, 5000),
                           $urandom_range(0, 10000), $urandom_range(0, 10000),
                           $urandom_range(0, 10000), $urandom_range(0, 10000),
                           $urandom_range(0, 30000), $urandom_range(0, 1));
            run_random(100);
        end
    endtask

    // receiver stalls for a long stretch while samples keep coming
    task automatic test_output_backpressure();
        apply_settings(50, 200, 100, 100, 1000, 1000, 4000, 1);
        sender_steady = 1'b1;
        hold_request  = 1'b1;
        run_random(40);
        sender_steady = 1'b0;
    endtask

    task automatic test_sender_pause();
        run_random(30);
        drain_status();
        run_random(30);
    endtask

    initial begin : status_sink
        int                hold;
        dhrc_pkg::result_t got;
        dhrc_pkg::result_t want;
        status_ch.ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever begin
            hold = receiver_steady ? 0 : $urandom_range(0, 8);
            if (hold_request) begin
                hold         = LONG_HOLD;
                hold_request = 1'b0;
            end
            if (hold > 0) begin
                status_ch.ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            status_ch.ready <= 1'b1;
            do @(posedge clk); while (!status_ch.valid);
            got = {status_ch.heater_on, status_ch.humidifier_on, status_ch.buzzer_on,
                   status_ch.temp_alarm, status_ch.humidity_alarm, status_ch.tick_taken};
            if (expected_status.size() == 0) begin
                flag_mismatch("status word with nothing pending", '0, got);
            end else begin
                want = expected_status.pop_front();
                if (got !== want)
                    flag_mismatch("status word", want, got);
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (sample_ch.valid && sample_ch.ready) || (status_ch.valid && status_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin : watchdog
        wait (idle_cycles >= STALL_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : run
        regs_model.temp_hysteresis     = 13'd50;
        regs_model.humidity_hysteresis = 13'd200;
        regs_model.temp_alarm_high     = 14'd100;
        regs_model.temp_alarm_low      = 14'd100;
        regs_model.humidity_alarm_high = 14'd1000;
        regs_model.humidity_alarm_low  = 14'd1000;
        regs_model.alarm_confirm_time  = 32'd60000;
        regs_model.buzzer_enable       = 1'b1;
        psel                           <= 1'b0;
        penable                        <= 1'b0;
        pwrite                         <= 1'b0;
        paddr                          <= '0;
        pwdata                         <= '0;
        sample_ch.valid                <= 1'b0;
        sample_ch.now_ms               <= '0;
        sample_ch.temp_reading         <= '0;
        sample_ch.temp_target          <= '0;
        sample_ch.humidity_reading     <= '0;
        sample_ch.humidity_target      <= '0;
        sample_ch.temp_sensor_good     <= 1'b0;
        sample_ch.humidity_sensor_good <= 1'b0;
        sample_ch.manual_override      <= 1'b0;
        sample_ch.safe_mode            <= 1'b0;
        sample_ch.batch_running        <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_settings_sweep();
        test_output_backpressure();
        test_sender_pause();

        drain_status();
        mismatches += expected_status.size();
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
